// ===== sv/pels_pkg.sv =====
// Shared types and constants for the per-event log suppressor.
// No dependencies; imported by every module of the block.
package pels_pkg;

	// Record table depth and its index width.
	localparam int ENTRIES = 64;
	localparam int SLOT_W  = $clog2(ENTRIES);

	// Input identifier range and field widths.
	localparam int ID_W     = 6;
	localparam int ID_RANGE = 1 << ID_W;
	localparam int TIME_W   = 32;
	localparam int CNT_W    = 32;
	localparam int WIN_W    = 24;
	localparam int THR_W    = 16;
	localparam int LIMIT_W  = 28;

	// Event-count period of the idle sweep, and idle age in windows.
	localparam int SWEEP_PERIOD = 100;
	localparam int SWEEP_W      = 7;
	localparam int IDLE_WINDOWS = 10;

	// Step counter of the remainder unit.
	localparam int REM_STEP_W = $clog2(CNT_W);

	// One record as it travels along the ring of cells.
	typedef struct packed {
		logic              vld;
		logic [TIME_W-1:0] ws;
		logic [TIME_W-1:0] ls;
		logic [CNT_W-1:0]  occ;
		logic [CNT_W-1:0]  sup;
	} rec_t;

	// Status from the remainder unit.
	typedef struct packed {
		logic done;
		logic zero;
	} rem_stat_t;

	// Identifier to record slot, built at elaboration.
	typedef logic [SLOT_W-1:0] slot_tab_t [ID_RANGE];

	function automatic slot_tab_t build_slot_tab();
		slot_tab_t tab;
		for (int i = 0; i < ID_RANGE; i++) begin
			tab[i] = SLOT_W'(i % ENTRIES);
		end
		return tab;
	endfunction

	localparam slot_tab_t SLOT_TAB = build_slot_tab();

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

// ===== sv/pels_cell.sv =====
// One cell of the record ring: registers a record and passes it on.
// Depends on pels_pkg (rec_t).
module pels_cell import pels_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  rec_t d,
	output rec_t q
);

	logic              vld_q;
	logic [TIME_W-1:0] ws_q;
	logic [TIME_W-1:0] ls_q;
	logic [CNT_W-1:0]  occ_q;
	logic [CNT_W-1:0]  sup_q;

	// valid bits clear at reset and on a table clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.vld & ~clr;
		end
	end

	always_ff @(posedge clk) begin
		ws_q  <= d.ws;
		ls_q  <= d.ls;
		occ_q <= d.occ;
		sup_q <= d.sup;
	end

	assign q = '{vld: vld_q, ws: ws_q, ls: ls_q, occ: occ_q, sup: sup_q};

endmodule

// ===== sv/pels_rem.sv =====
// Bit-serial remainder unit: dividend mod divisor, one bit per cycle.
// Depends on pels_pkg (widths, rem_stat_t).
module pels_rem import pels_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [CNT_W-1:0] dividend,
	input  logic [THR_W-1:0] divisor,
	output rem_stat_t        stat
);

	logic                  run_q;
	logic                  done_q;
	logic [REM_STEP_W-1:0] step_q;
	logic [CNT_W-1:0]      dvd_q;
	logic [THR_W-1:0]      div_q;
	logic [THR_W-1:0]      rem_q;
	logic [THR_W:0]        shifted;
	logic [THR_W:0]        diff;
	logic                  fits;

	assign shifted = {rem_q, dvd_q[CNT_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = (shifted >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == REM_STEP_W'(CNT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[CNT_W-2:0], 1'b0};
			rem_q <= fits ? diff[THR_W-1:0] : shifted[THR_W-1:0];
		end
	end

	assign stat = '{done: done_q, zero: (rem_q == '0)};

endmodule

// ===== sv/per_event_log_suppressor_core.sv =====
// Per-event log suppressor: a windowed "log every Nth" rate limiter, top level.
// Depends on pels_pkg, pels_cell (record ring) and pels_rem (remainder unit).
//
// An item is a transfer taken when start is high and busy is low. func = 0
// reports an event for slot event_id at time now_ms; exactly one result
// follows, shown for a single cycle with done high, and the receiver must take
// it then, as nothing holds it. func = 1 empties the record table in the cycle
// it is taken and gives no result; busy stays low. The records live in a ring
// of ENTRIES cells that shifts by one every cycle; all reads and writes happen
// where the ring closes, so an event waits for its record to come around,
// once to read it and once to write it back. For a report, the record is
// captured as it leaves the ring and written back on its next pass, and the
// bit-serial remainder unit for an in-window event finishes inside that turn.
// Every 100th report first spends a full turn of the ring dropping records
// idle for more than ten windows, with the lookup done in the same turn; when
// the remainder unit then misses the record's next pass, such a report writes
// its record back on the pass after that. busy is high from the cycle after
// the transfer until the result cycle, in which the next item can already be
// taken. There is no clearing pass after reset. The window length (address
// 0x0) and threshold (0x4) must be written over the APB port only while busy
// is low and no result is pending; the block itself does not enforce this. A
// threshold of zero acts as one.
module per_event_log_suppressor_core import pels_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// item channel
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [ID_W-1:0]   event_id,
	input  logic [TIME_W-1:0] now_ms,
	// result channel
	output logic              done,
	output logic              log_it,
	output logic [TIME_W-1:0] window_start_ms,
	output logic [TIME_W-1:0] last_seen_ms,
	output logic [CNT_W-1:0]  event_count,
	output logic [CNT_W-1:0]  suppressed_count,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// register map (word index from paddr[2])
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DSTART = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_WB     = 3'd4;

	logic [2:0]         state_q;
	logic [2:0]         state_d;

	logic [WIN_W-1:0]   window_q;
	logic [THR_W-1:0]   threshold_q;
	logic [THR_W-1:0]   thr_eff;

	// item context
	logic [SLOT_W-1:0]  slot_q;
	logic [TIME_W-1:0]  now_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               sweep_q;
	logic [SWEEP_W-1:0] sweep_cnt_q;
	logic [SWEEP_W-1:0] sweep_nxt;
	logic [SLOT_W-1:0]  scan_cnt_q;

	// ring
	logic [SLOT_W-1:0]  head_q;
	rec_t               ring_q [ENTRIES];
	rec_t               exit_rec;
	rec_t               feed;
	rec_t               upd_rec;

	// captured record of the target slot
	logic               new_win_q;
	logic [TIME_W-1:0]  ws_cap_q;
	logic [CNT_W-1:0]   occ_inc_q;
	logic [CNT_W-1:0]   sup_cap_q;
	logic [CNT_W-1:0]   sup_inc_q;
	logic               rem_zero_q;

	logic               accept;
	logic               clr;
	logic               tgt_hit;
	logic               wb_hit;
	logic               scan_end;
	logic [TIME_W-1:0]  age_ls;
	logic [TIME_W-1:0]  age_ws;
	logic               drop_idle;
	logic               vld_eff;
	logic               expired;
	logic               rem_go;
	rem_stat_t          rem_stat;
	logic               cfg_wr;

	// result registers
	logic               done_q;
	logic               log_q;
	logic [TIME_W-1:0]  ws_out_q;
	logic [TIME_W-1:0]  ls_out_q;
	logic [CNT_W-1:0]   occ_out_q;
	logic [CNT_W-1:0]   sup_out_q;

	//------------------------------------------------------------------
	// configuration port
	//------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WIN_W'(1000);
			threshold_q <= THR_W'(10);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WINDOW: window_q    <= pwdata[WIN_W-1:0];
				REG_THRESH: threshold_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW: prdata = {{(32-WIN_W){1'b0}}, window_q};
			REG_THRESH: prdata = {{(32-THR_W){1'b0}}, threshold_q};
			default:    prdata = '0;
		endcase
	end

	assign thr_eff = (threshold_q == '0) ? THR_W'(1) : threshold_q;

	//------------------------------------------------------------------
	// item intake
	//------------------------------------------------------------------
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start & ~busy;
	assign clr       = accept & func;          // table clear, broadcast to all cells
	assign sweep_nxt = sweep_cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
			sweep_q     <= 1'b0;
		end else if (accept && !func) begin
			if (sweep_nxt >= SWEEP_W'(SWEEP_PERIOD)) begin
				sweep_cnt_q <= '0;
				sweep_q     <= 1'b1;
			end else begin
				sweep_cnt_q <= sweep_nxt;
				sweep_q     <= 1'b0;
			end
		end else if (scan_end) begin
			sweep_q <= 1'b0;
		end
	end

	// limit = window * 10 as two shifted adds
	always_ff @(posedge clk) begin
		if (accept && !func) begin
			slot_q  <= SLOT_TAB[event_id];
			now_q   <= now_ms;
			limit_q <= {1'b0, window_q, 3'b000} + {3'b000, window_q, 1'b0};
		end
	end

	//------------------------------------------------------------------
	// record ring: cell g takes from cell g+1, the last cell from the feed
	//------------------------------------------------------------------
	for (genvar g = 0; g < ENTRIES; g++) begin : g_ring
		rec_t cell_d;
		if (g == ENTRIES - 1) begin : g_last
			assign cell_d = feed;
		end else begin : g_mid
			assign cell_d = ring_q[g+1];
		end
		pels_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clr    (clr),
			.d      (cell_d),
			.q      (ring_q[g])
		);
	end

	assign exit_rec = ring_q[0];

	// slot currently leaving cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q <= (head_q == SLOT_W'(ENTRIES - 1)) ? '0 : head_q + 1'b1;
		end
	end

	// idle drop and window checks on the record at the ring's exit
	assign age_ls    = now_q - exit_rec.ls;
	assign age_ws    = now_q - exit_rec.ws;
	assign drop_idle = (state_q == ST_SCAN) && sweep_q && exit_rec.vld &&
	                   (age_ls > {{(TIME_W-LIMIT_W){1'b0}}, limit_q});
	assign vld_eff   = exit_rec.vld & ~drop_idle;
	assign expired   = (age_ws > {{(TIME_W-WIN_W){1'b0}}, window_q});

	assign tgt_hit  = (state_q == ST_SCAN) && (head_q == slot_q);
	assign wb_hit   = (state_q == ST_WB) && (head_q == slot_q);
	// a sweep takes one full turn; a plain lookup ends at its slot
	assign scan_end = (state_q == ST_SCAN) &&
	                  (sweep_q ? (scan_cnt_q == SLOT_W'(ENTRIES - 1)) : tgt_hit);

	// updated record for write-back
	always_comb begin
		if (new_win_q) begin
			upd_rec = '{vld: 1'b1, ws: now_q, ls: now_q, occ: CNT_W'(1), sup: '0};
		end else begin
			upd_rec = '{vld: 1'b1, ws: ws_cap_q, ls: now_q, occ: occ_inc_q,
			            sup: rem_zero_q ? '0 : sup_inc_q};
		end
	end

	always_comb begin
		feed = exit_rec;
		if (wb_hit) begin
			feed = upd_rec;
		end else begin
			feed.vld = vld_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			scan_cnt_q <= scan_cnt_q + 1'b1;
		end else begin
			scan_cnt_q <= '0;
		end
	end

	// capture the target record as it passes
	always_ff @(posedge clk) begin
		if (tgt_hit) begin
			new_win_q <= ~vld_eff | expired;
			ws_cap_q  <= exit_rec.ws;
			occ_inc_q <= sat_inc(exit_rec.occ);
			sup_cap_q <= exit_rec.sup;
			sup_inc_q <= sat_inc(exit_rec.sup);
		end
		if (rem_stat.done) begin
			rem_zero_q <= rem_stat.zero;
		end
	end

	//------------------------------------------------------------------
	// occurrence count mod threshold
	//------------------------------------------------------------------
	assign rem_go = (state_q == ST_DSTART) && !new_win_q;

	pels_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (rem_go),
		.dividend (occ_inc_q),
		.divisor  (thr_eff),
		.stat     (rem_stat)
	);

	//------------------------------------------------------------------
	// sequencer
	//------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && !func) state_d = ST_SCAN;
			ST_SCAN:   if (scan_end) state_d = ST_DSTART;
			ST_DSTART: state_d = new_win_q ? ST_WB : ST_DIV;
			ST_DIV:    if (rem_stat.done) state_d = ST_WB;
			ST_WB:     if (wb_hit) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	//------------------------------------------------------------------
	// result transfer
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= wb_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_hit) begin
			log_q     <= new_win_q | rem_zero_q;
			ws_out_q  <= upd_rec.ws;
			ls_out_q  <= upd_rec.ls;
			occ_out_q <= upd_rec.occ;
			// a logged in-window event shows the count it clears
			if (new_win_q) begin
				sup_out_q <= '0;
			end else begin
				sup_out_q <= rem_zero_q ? sup_cap_q : sup_inc_q;
			end
		end
	end

	assign done             = done_q;
	assign log_it           = log_q;
	assign window_start_ms  = ws_out_q;
	assign last_seen_ms     = ls_out_q;
	assign event_count      = occ_out_q;
	assign suppressed_count = sup_out_q;

	//------------------------------------------------------------------
	// assertions
	//------------------------------------------------------------------
`ifndef ASSERT_OFF
	a_done_after_wb: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_WB && head_q == slot_q))
		else $error("result strobe without a write-back of the target slot");

	a_rem_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_stat.done |-> (state_q == ST_DIV))
		else $error("remainder finished outside the divide phase");

	a_sweep_full_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sweep_q && scan_cnt_q != SLOT_W'(ENTRIES - 1))
		|=> (state_q == ST_SCAN))
		else $error("idle sweep left the ring before a full turn");
`endif

endmodule
